// ----- src/gasp_pkg.sv -----
`default_nettype none

package gasp_pkg;

  // atlas geometry
  localparam int MAX_SHEETS = 16;
  localparam int SHEET_DIM  = 256;

  // field and storage widths
  localparam int CRD_W = 9;                        // coordinates and box extents
  localparam int SUM_W = CRD_W + 1;                // coordinate plus extent
  localparam int IDX_W = $clog2(MAX_SHEETS);       // sheet address
  localparam int CNT_W = $clog2(MAX_SHEETS + 1);   // sheet count, holds MAX_SHEETS

  // one input transaction
  typedef struct packed {
    logic [CRD_W-1:0] box_width;
    logic [CRD_W-1:0] box_height;
  } box_t;

  // one result transaction
  typedef struct packed {
    logic [3:0]       sheet_index;
    logic [CRD_W-1:0] place_x;
    logic [CRD_W-1:0] place_y;
    logic             opened_sheet;
    logic             atlas_full;
  } place_t;

  // per-sheet shelf record, one memory word
  typedef struct packed {
    logic [CRD_W-1:0] cursor_x;
    logic [CRD_W-1:0] top_y;
    logic [CRD_W-1:0] bottom_y;
  } shelf_t;

  // outcome of trying one sheet
  typedef struct packed {
    logic             hit;
    logic [CRD_W-1:0] place_x;
    logic [CRD_W-1:0] place_y;
    shelf_t           upd;
  } fit_t;

endpackage

`default_nettype wire

// ----- src/gasp_shelf_mem.sv -----
`default_nettype none

module gasp_shelf_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [gasp_pkg::IDX_W-1:0] waddr,
  input  wire gasp_pkg::shelf_t           wdata,
  input  wire logic [gasp_pkg::IDX_W-1:0] raddr,
  output gasp_pkg::shelf_t                rdata
);

  // shelf records, one word per sheet
  gasp_pkg::shelf_t mem [gasp_pkg::MAX_SHEETS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/gasp_fit.sv -----
`default_nettype none

module gasp_fit (
  input  wire gasp_pkg::shelf_t                 cur,
  input  wire logic [gasp_pkg::CRD_W-1:0]       box_w,
  input  wire logic [gasp_pkg::CRD_W-1:0]       box_h,
  output gasp_pkg::fit_t                        fit
);

  localparam logic [gasp_pkg::SUM_W-1:0] DIM = gasp_pkg::SUM_W'(gasp_pkg::SHEET_DIM);

  logic [gasp_pkg::SUM_W-1:0] cx_sum;
  logic [gasp_pkg::SUM_W-1:0] ty_sum;
  logic [gasp_pkg::SUM_W-1:0] by_sum;
  logic [gasp_pkg::SUM_W-1:0] cx_adv;
  logic [gasp_pkg::SUM_W-1:0] w_adv;

  // extents reached by the box on this sheet
  assign cx_sum = {1'b0, cur.cursor_x} + {1'b0, box_w};
  assign ty_sum = {1'b0, cur.top_y} + {1'b0, box_h};
  assign by_sum = {1'b0, cur.bottom_y} + {1'b0, box_h};
  assign cx_adv = cx_sum + gasp_pkg::SUM_W'(1);
  assign w_adv  = {1'b0, box_w} + gasp_pkg::SUM_W'(1);

  // current shelf first, else a new shelf at the bottom extent
  always_comb begin
    if (cx_sum <= DIM) begin
      fit.hit          = (ty_sum <= DIM);
      fit.place_x      = cur.cursor_x;
      fit.place_y      = cur.top_y;
      fit.upd.cursor_x = cx_adv[gasp_pkg::CRD_W-1:0];
      fit.upd.top_y    = cur.top_y;
      fit.upd.bottom_y = (ty_sum > {1'b0, cur.bottom_y}) ? ty_sum[gasp_pkg::CRD_W-1:0]
                                                        : cur.bottom_y;
    end else begin
      fit.hit          = (by_sum <= DIM);
      fit.place_x      = '0;
      fit.place_y      = cur.bottom_y;
      fit.upd.cursor_x = w_adv[gasp_pkg::CRD_W-1:0];
      fit.upd.top_y    = cur.bottom_y;
      fit.upd.bottom_y = by_sum[gasp_pkg::CRD_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- src/glyph_atlas_shelf_packer.sv -----
`default_nettype none

// First-fit shelf packer for glyph atlas sheets. Each box transaction gives
// exactly one place transaction: the sheet, the top-left offset and flags;
// a box wider or taller than a sheet, or one that fits no open sheet while
// all sheets are in use, comes back with atlas_full set and all other fields
// zero, and leaves the atlas untouched. Shelf records live in a synchronous
// memory with one read and one write port that is read one sheet per cycle
// in ascending order, so a box that lands on sheet k gets its result once
// sheets 0 to k have been read, and a box that opens a new sheet or finds
// the atlas full gets it once all N sheets in use have been read; oversized
// boxes skip the scan and go straight to the output register.
// One box is in work at a time; the next box is accepted while the previous
// result still waits in the output register. No clearing pass is needed
// after reset: only opened sheets are ever read, and opening writes them.
module glyph_atlas_shelf_packer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              box_valid,
  output logic                   box_stall,
  input  wire gasp_pkg::box_t    box,
  output logic                   place_valid,
  input  wire logic              place_stall,
  output gasp_pkg::place_t       place
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  localparam logic [gasp_pkg::SUM_W-1:0] DIM = gasp_pkg::SUM_W'(gasp_pkg::SHEET_DIM);
  localparam logic [gasp_pkg::CNT_W-1:0] SHEETS_MAX =
    gasp_pkg::CNT_W'(gasp_pkg::MAX_SHEETS);

  // rejected box: only the full flag set
  localparam gasp_pkg::place_t RES_FULL = '{sheet_index: '0, place_x: '0, place_y: '0,
                                           opened_sheet: 1'b0, atlas_full: 1'b1};

  state_t                       state;
  logic [gasp_pkg::CNT_W-1:0]   sheets_in_use;
  logic [gasp_pkg::CNT_W-1:0]   issue_cnt;
  logic                         rvalid;
  logic [gasp_pkg::IDX_W-1:0]   ridx;
  logic [gasp_pkg::CRD_W-1:0]   box_w;
  logic [gasp_pkg::CRD_W-1:0]   box_h;
  gasp_pkg::place_t             res;

  logic                         box_acc;
  logic                         oversize;
  logic                         hit_now;
  logic                         scan_end;
  logic                         issue;
  logic                         open_new;
  logic                         at_limit;
  logic                         mem_we;
  logic [gasp_pkg::IDX_W-1:0]   mem_waddr;
  gasp_pkg::shelf_t             mem_q;
  gasp_pkg::shelf_t             eval_cur;
  gasp_pkg::fit_t               fit;
  logic                         load_out;

  // shelf record storage
  gasp_shelf_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (fit.upd),
    .raddr (issue_cnt[gasp_pkg::IDX_W-1:0]),
    .rdata (mem_q)
  );

  // a fresh sheet looks like an all-zero record
  assign eval_cur = rvalid ? mem_q : '0;

  gasp_fit u_fit (
    .cur   (eval_cur),
    .box_w (box_w),
    .box_h (box_h),
    .fit   (fit)
  );

  // input side
  assign box_stall = (state != ST_IDLE);
  assign box_acc   = box_valid && !box_stall;
  assign oversize  = ({1'b0, box.box_width} > DIM) || ({1'b0, box.box_height} > DIM);

  // scan control: evaluate the record read last cycle, fetch the next one
  assign hit_now   = (state == ST_SCAN) && rvalid && fit.hit;
  assign scan_end  = (state == ST_SCAN) && !rvalid && (issue_cnt == sheets_in_use);
  assign issue     = (state == ST_SCAN) && !hit_now && (issue_cnt < sheets_in_use);
  assign at_limit  = (sheets_in_use == SHEETS_MAX);
  assign open_new  = scan_end && !at_limit;
  assign mem_we    = hit_now || open_new;
  assign mem_waddr = hit_now ? ridx : sheets_in_use[gasp_pkg::IDX_W-1:0];

  // output register frees as soon as the sink takes its transaction
  assign load_out = (state == ST_FIN) && (!place_valid || !place_stall);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sheets_in_use <= '0;
      issue_cnt     <= '0;
      rvalid        <= 1'b0;
      place_valid   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (box_acc) begin
            state     <= oversize ? ST_FIN : ST_SCAN;
            issue_cnt <= '0;
            rvalid    <= 1'b0;
          end
        end
        ST_SCAN: begin
          rvalid <= issue;
          if (issue) begin
            issue_cnt <= issue_cnt + gasp_pkg::CNT_W'(1);
          end
          if (open_new) begin
            sheets_in_use <= sheets_in_use + gasp_pkg::CNT_W'(1);
          end
          if (hit_now || scan_end) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (load_out) begin
        place_valid <= 1'b1;
      end else if (place_valid && !place_stall) begin
        place_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (box_acc) begin
      box_w <= box.box_width;
      box_h <= box.box_height;
      res   <= oversize ? RES_FULL : gasp_pkg::place_t'('0);
    end
    if (issue) begin
      ridx <= issue_cnt[gasp_pkg::IDX_W-1:0];
    end
    if (mem_we) begin
      res.sheet_index  <= 4'(mem_waddr);
      res.place_x      <= fit.place_x;
      res.place_y      <= fit.place_y;
      res.opened_sheet <= open_new;
      res.atlas_full   <= 1'b0;
    end else if (scan_end) begin
      res <= RES_FULL;
    end
    if (load_out) begin
      place <= res;
    end
  end

  // sheet count never runs past the atlas size
  a_in_use_bound: assert property (@(posedge clk) disable iff (rst)
    sheets_in_use <= SHEETS_MAX)
    else $error("sheet count above atlas size");

  // records are only fetched for sheets that were opened
  a_read_opened: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> ({1'b0, ridx} < sheets_in_use))
    else $error("record read for an unopened sheet");

  // opening a sheet bumps the count by exactly one
  a_open_count: assert property (@(posedge clk) disable iff (rst)
    open_new |=> (sheets_in_use == $past(sheets_in_use) + gasp_pkg::CNT_W'(1)))
    else $error("sheet count did not follow an opened sheet");

  // a rejected box carries no placement
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (place_valid && place.atlas_full) |->
      (!place.opened_sheet && place.sheet_index == '0 && place.place_x == '0 &&
       place.place_y == '0))
    else $error("rejected box carries placement fields");

  // the memory is written only while scanning
  a_write_scan: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_SCAN))
    else $error("shelf record written outside a scan");

endmodule

`default_nettype wire
